### hdl/lssrc_pkg.sv
package lssrc_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int MAX_LAYERS  = 4;
    localparam int COUNT_BITS  = 8;

    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int LAYER_W     = $clog2(MAX_LAYERS);
    localparam int ADDR_W      = LAYER_W + COL_W + ROW_W;
    localparam int TABLE_DEPTH = MAX_LAYERS * MAX_WIDTH * MAX_HEIGHT;

    localparam int ENTRY_W     = 24;
    localparam int TOTAL_W     = 26;
    localparam int COORD_W     = 16;
    localparam int CFG_W       = 9;
    localparam int CFG_IDX_W   = 2;

    localparam int IN_TDATA_W  = 80;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 56;

    // tdata field positions of an input beat
    localparam int CNT_LSB     = 0;
    localparam int XL_LSB      = 8;
    localparam int YL_LSB      = 24;
    localparam int XH_LSB      = 40;
    localparam int YH_LSB      = 56;
    localparam int FL_LSB      = 72;
    localparam int LL_LSB      = 74;

    typedef enum logic [0:0] {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_LAYER_COUNT = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        CORNER_BASE  = 2'd0,
        CORNER_TOP   = 2'd1,
        CORNER_RIGHT = 2'd2,
        CORNER_DIAG  = 2'd3
    } t_corner;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_CLIP,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic ld_write;
        logic q_clip;
        logic q_issue;
        logic q_out;
    } t_cmd;

    typedef struct packed {
        logic q_empty;
        logic q_last;
        logic out_free;
    } t_status;

endpackage

### hdl/lssrc_ctrl.sv
module lssrc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_op,
    input  lssrc_pkg::t_status i_status,
    output logic               o_ready,
    output lssrc_pkg::t_cmd    o_cmd
);
    import lssrc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = (i_op == OP_LOAD) ? ST_LOAD : ST_CLIP;
                end
            end
            ST_LOAD:  n_state = ST_IDLE;
            ST_CLIP:  n_state = i_status.q_empty ? ST_DONE : ST_READ;
            ST_READ: begin
                if (i_status.q_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_DONE;
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready        = 1'b0;
        o_cmd          = '0;
        case (r_state)
            ST_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
            end
            ST_LOAD:  o_cmd.ld_write = 1'b1;
            ST_CLIP:  o_cmd.q_clip   = 1'b1;
            ST_READ:  o_cmd.q_issue  = 1'b1;
            ST_DRAIN: o_cmd          = '0;
            ST_DONE:  o_cmd.q_out    = i_status.out_free;
            default:  o_cmd          = '0;
        endcase
    end

endmodule

### hdl/lssrc_dpath.sv
module lssrc_dpath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  lssrc_pkg::t_cmd                    i_cmd,
    output lssrc_pkg::t_status                 o_status,
    input  logic [lssrc_pkg::IN_TDATA_W-1:0]   i_tdata,
    input  logic                               i_cfg_we,
    input  logic [lssrc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lssrc_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                               i_m_tready,
    output logic                               o_m_tvalid,
    output logic [lssrc_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);
    import lssrc_pkg::*;

    function automatic logic [CFG_W-1:0] cfg_m1(input logic [CFG_W-1:0] v,
                                                input logic [CFG_W-1:0] mx);
        logic [CFG_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (v > mx) begin
            res = mx - 1'b1;
        end else begin
            res = v - 1'b1;
        end
        return res;
    endfunction

    // storage
    logic [ENTRY_W-1:0] r_table  [0:TABLE_DEPTH-1];
    logic [ENTRY_W-1:0] r_colbuf [0:MAX_HEIGHT-1];

    // effective configuration, kept as value minus one
    logic [COL_W-1:0]   r_wm1, n_wm1;
    logic [ROW_W-1:0]   r_hm1, n_hm1;
    logic [LAYER_W-1:0] r_lm1, n_lm1;
    logic [CFG_W-1:0]   w_cfg_w, w_cfg_h, w_cfg_l;
    logic               w_cfg_hit;

    // load position and running values
    logic [LAYER_W-1:0] r_layer;
    logic [COL_W-1:0]   r_col;
    logic [ROW_W-1:0]   r_row;
    logic [TOTAL_W-1:0] r_gt;
    logic [ENTRY_W-1:0] r_right, r_up, r_diag;

    // captured beat
    logic [COUNT_BITS-1:0] r_cnt;
    logic [COORD_W-1:0]    r_xl, r_yl, r_xh, r_yh;
    logic [LAYER_W-1:0]    r_fl, r_ll;

    // query state
    logic [COL_W-1:0]   r_a, r_xe;
    logic [ROW_W-1:0]   r_b, r_ye;
    logic               r_in_x, r_in_y;
    logic [LAYER_W-1:0] r_llc, r_ql;
    logic [1:0]         r_corner;
    logic [ENTRY_W-1:0] r_rd_data;
    logic               r_tag_vld, r_tag_en;
    logic [1:0]         r_tag_corner;
    logic [ENTRY_W-1:0] r_part;
    logic [TOTAL_W-1:0] r_sum;

    logic               r_out_valid;
    logic [TOTAL_W-1:0] r_out_region, r_out_total;

    // ---------------- configuration ----------------
    assign w_cfg_w = cfg_m1(i_cfg_data, CFG_W'(MAX_WIDTH));
    assign w_cfg_h = cfg_m1(i_cfg_data, CFG_W'(MAX_HEIGHT));
    assign w_cfg_l = cfg_m1(CFG_W'(i_cfg_data[2:0]), CFG_W'(MAX_LAYERS));

    always_comb begin
        n_wm1     = r_wm1;
        n_hm1     = r_hm1;
        n_lm1     = r_lm1;
        w_cfg_hit = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_GRID_WIDTH: begin
                    n_wm1     = w_cfg_w[COL_W-1:0];
                    w_cfg_hit = 1'b1;
                end
                CFG_GRID_HEIGHT: begin
                    n_hm1     = w_cfg_h[ROW_W-1:0];
                    w_cfg_hit = 1'b1;
                end
                CFG_LAYER_COUNT: begin
                    n_lm1     = w_cfg_l[LAYER_W-1:0];
                    w_cfg_hit = 1'b1;
                end
                default: w_cfg_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm1 <= COL_W'(MAX_WIDTH - 1);
            r_hm1 <= ROW_W'(MAX_HEIGHT - 1);
            r_lm1 <= '0;
        end else begin
            r_wm1 <= n_wm1;
            r_hm1 <= n_hm1;
            r_lm1 <= n_lm1;
        end
    end

    // ---------------- beat capture ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cnt   <= i_tdata[CNT_LSB +: COUNT_BITS];
            r_xl    <= i_tdata[XL_LSB +: COORD_W];
            r_yl    <= i_tdata[YL_LSB +: COORD_W];
            r_xh    <= i_tdata[XH_LSB +: COORD_W];
            r_yh    <= i_tdata[YH_LSB +: COORD_W];
            r_fl    <= i_tdata[FL_LSB +: LAYER_W];
            r_ll    <= i_tdata[LL_LSB +: LAYER_W];
            r_right <= r_colbuf[r_row];
        end
    end

    // ---------------- load ----------------
    logic               w_has_right, w_has_up, w_start;
    logic [ENTRY_W-1:0] w_right_m, w_up_m, w_diag_m, w_entry;

    assign w_has_right = (r_col != r_wm1);
    assign w_has_up    = (r_row != r_hm1);
    assign w_right_m   = w_has_right ? r_right : '0;
    assign w_up_m      = w_has_up ? r_up : '0;
    assign w_diag_m    = (w_has_right && w_has_up) ? r_diag : '0;
    assign w_entry     = ENTRY_W'(r_cnt) + w_right_m + w_up_m - w_diag_m;
    assign w_start     = (r_layer == r_lm1) && (r_col == r_wm1) && (r_row == r_hm1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_write) begin
            r_up   <= w_entry;
            r_diag <= r_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer <= '0;
            r_col   <= COL_W'(MAX_WIDTH - 1);
            r_row   <= ROW_W'(MAX_HEIGHT - 1);
            r_gt    <= '0;
        end else if (w_cfg_hit) begin
            // any register write restarts the pass
            r_layer <= n_lm1;
            r_col   <= n_wm1;
            r_row   <= n_hm1;
        end else if (i_cmd.ld_write) begin
            r_gt <= w_start ? TOTAL_W'(r_cnt) : r_gt + TOTAL_W'(r_cnt);
            if (r_row != '0) begin
                r_row <= r_row - 1'b1;
            end else begin
                r_row <= r_hm1;
                if (r_col != '0) begin
                    r_col <= r_col - 1'b1;
                end else begin
                    r_col   <= r_wm1;
                    r_layer <= (r_layer != '0) ? r_layer - 1'b1 : r_lm1;
                end
            end
        end
    end

    // ---------------- query clip ----------------
    logic signed [COORD_W:0] w_xl, w_yl, w_xh, w_yh, w_wlim, w_hlim, w_xh_s, w_yh_s;
    logic [LAYER_W-1:0]      w_llc;
    logic [COL_W-1:0]        w_xh8;
    logic [ROW_W-1:0]        w_yh8;
    logic                    w_empty;

    assign w_wlim = $signed({{(COORD_W + 1 - COL_W){1'b0}}, r_wm1});
    assign w_hlim = $signed({{(COORD_W + 1 - ROW_W){1'b0}}, r_hm1});
    assign w_xh_s = $signed({r_xh[COORD_W-1], r_xh});
    assign w_yh_s = $signed({r_yh[COORD_W-1], r_yh});
    assign w_xl   = r_xl[COORD_W-1] ? '0 : $signed({1'b0, r_xl});
    assign w_yl   = r_yl[COORD_W-1] ? '0 : $signed({1'b0, r_yl});
    assign w_xh   = (w_xh_s > w_wlim) ? w_wlim : w_xh_s;
    assign w_yh   = (w_yh_s > w_hlim) ? w_hlim : w_yh_s;
    assign w_llc  = (r_ll > r_lm1) ? r_lm1 : r_ll;
    assign w_empty = (w_xl > w_xh) || (w_yl > w_yh) || (r_fl > w_llc);
    assign w_xh8  = w_xh[COL_W-1:0];
    assign w_yh8  = w_yh[ROW_W-1:0];

    // ---------------- corner reads ----------------
    logic [COL_W-1:0] w_rd_col;
    logic [ROW_W-1:0] w_rd_row;
    logic             w_rd_en;

    always_comb begin
        w_rd_col = r_a;
        w_rd_row = r_b;
        w_rd_en  = 1'b1;
        case (r_corner)
            CORNER_BASE: begin
                w_rd_col = r_a;
                w_rd_row = r_b;
                w_rd_en  = 1'b1;
            end
            CORNER_TOP: begin
                w_rd_col = r_a;
                w_rd_row = r_ye;
                w_rd_en  = r_in_y;
            end
            CORNER_RIGHT: begin
                w_rd_col = r_xe;
                w_rd_row = r_b;
                w_rd_en  = r_in_x;
            end
            CORNER_DIAG: begin
                w_rd_col = r_xe;
                w_rd_row = r_ye;
                w_rd_en  = r_in_x && r_in_y;
            end
            default: begin
                w_rd_col = r_a;
                w_rd_row = r_b;
                w_rd_en  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_write) begin
            r_table[{r_layer, r_col, r_row}] <= w_entry;
            r_colbuf[r_row]                  <= w_entry;
        end
        if (i_cmd.q_issue) begin
            r_rd_data <= r_table[{r_ql, w_rd_col, w_rd_row}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_clip) begin
            r_a      <= w_xl[COL_W-1:0];
            r_b      <= w_yl[ROW_W-1:0];
            r_xe     <= w_xh8 + 1'b1;
            r_ye     <= w_yh8 + 1'b1;
            r_in_x   <= (w_xh8 != r_wm1);
            r_in_y   <= (w_yh8 != r_hm1);
            r_llc    <= w_llc;
            r_ql     <= r_fl;
            r_corner <= CORNER_BASE;
        end else if (i_cmd.q_issue) begin
            r_corner <= r_corner + 1'b1;
            if (r_corner == CORNER_DIAG) begin
                r_ql <= r_ql + 1'b1;
            end
        end
        if (i_cmd.q_issue) begin
            r_tag_corner <= r_corner;
            r_tag_en     <= w_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_vld <= 1'b0;
        end else begin
            r_tag_vld <= i_cmd.q_issue;
        end
    end

    // ---------------- accumulate ----------------
    logic [ENTRY_W-1:0] w_term, w_base, w_part;

    assign w_term = r_tag_en ? r_rd_data : '0;
    assign w_base = (r_tag_corner == CORNER_BASE) ? '0 : r_part;
    assign w_part = (r_tag_corner == CORNER_TOP || r_tag_corner == CORNER_RIGHT)
                    ? w_base - w_term : w_base + w_term;

    always_ff @(posedge i_clk) begin
        if (r_tag_vld) begin
            r_part <= w_part;
        end
        if (i_cmd.q_clip) begin
            r_sum <= '0;
        end else if (r_tag_vld && r_tag_corner == CORNER_DIAG) begin
            // close one layer
            r_sum <= r_sum + TOTAL_W'(w_part);
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.q_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.q_out) begin
            r_out_region <= r_sum;
            r_out_total  <= r_gt;
        end
    end

    assign o_m_tvalid        = r_out_valid;
    assign o_m_tdata         = OUT_TDATA_W'({r_out_total, r_out_region});
    assign o_status.q_empty  = w_empty;
    assign o_status.q_last   = (r_corner == CORNER_DIAG) && (r_ql == r_llc);
    assign o_status.out_free = !r_out_valid || i_m_tready;

endmodule

### hdl/layered_suffix_sum_region_counter.sv
// Load beat: accepted in IDLE, then written to the table in LOAD; the next beat is taken back in IDLE.
// Query over L layers: accepted in IDLE, clipped in CLIP, read in READ, drained in DRAIN, posted in DONE
// (an empty region goes from CLIP straight to DONE); one corner read per cycle on the table port in READ.
// A result not yet taken at the output holds a following query until the register frees.
// Reset (i_rst_n low, synchronous): config back to 256x256x1, load pass restarted,
// total cleared, output emptied; the table keeps its contents and needs no clearing.
module layered_suffix_sum_region_counter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // cell_count[7:0], x_low[23:8], y_low[39:24], x_high[55:40], y_high[71:56],
    // first_layer[73:72], last_layer[75:74], zero[79:76]
    input  logic [lssrc_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // op[0]
    input  logic [lssrc_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // region_count[25:0], total_count[51:26], zero[55:52]
    output logic [lssrc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [lssrc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lssrc_pkg::CFG_W-1:0]        i_cfg_data
);
    import lssrc_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    lssrc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_op     (s_axis_tuser[0]),
        .i_status (w_status),
        .o_ready  (s_axis_tready),
        .o_cmd    (w_cmd)
    );

    lssrc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_tdata     (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule

### hdl/lssrc_checker.sv
module lssrc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [lssrc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
    import lssrc_pkg::*;

    // output register is emptied by reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat present right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat changed");

    // one beat in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while previous beat still in work");

    // a result is only posted while the input side is closed
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result beat appeared without a query in work");

endmodule

bind layered_suffix_sum_region_counter lssrc_checker u_lssrc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

### test/layered_suffix_sum_region_counter_test.sv
module layered_suffix_sum_region_counter_test;
    import lssrc_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BEATS = 2000;

    typedef struct {
        t_op            op;
        bit [7:0]       cell_count;
        shortint        x_low;
        shortint        y_low;
        shortint        x_high;
        shortint        y_high;
        bit [1:0]       first_layer;
        bit [1:0]       last_layer;
    } t_cell_beat;

    typedef struct {
        bit [TOTAL_W-1:0] region_count;
        bit [TOTAL_W-1:0] total_count;
    } t_count_pair;

    class t_region_count_tracker;
        bit [ENTRY_W-1:0] suffix_mem [TABLE_DEPTH];
        bit               entry_written [TABLE_DEPTH];
        bit               unwritten_read;
        int unsigned      width_reg, height_reg, layers_reg;
        int unsigned      load_lyr, load_col, load_row;
        bit [TOTAL_W-1:0] pass_total;
        t_count_pair      pending_counts[$];
        int               errors;

        function new();
            width_reg  = 256;
            height_reg = 256;
            layers_reg = 1;
            pass_total = '0;
            errors     = 0;
            restart_pass();
        endfunction

        function int unsigned clamp_reg(int unsigned v, int unsigned top);
            if (v < 1) return 1;
            if (v > top) return top;
            return v;
        endfunction

        function int unsigned grid_cols();
            return clamp_reg(width_reg, MAX_WIDTH);
        endfunction

        function int unsigned grid_rows();
            return clamp_reg(height_reg, MAX_HEIGHT);
        endfunction

        function int unsigned grid_layers();
            return clamp_reg(layers_reg, MAX_LAYERS);
        endfunction

        function int unsigned slot(int unsigned l, int unsigned c, int unsigned r);
            return (l * MAX_WIDTH + c) * MAX_HEIGHT + r;
        endfunction

        function void restart_pass();
            load_lyr = grid_layers() - 1;
            load_col = grid_cols() - 1;
            load_row = grid_rows() - 1;
        endfunction

        function void write_config(t_cfg_index idx, bit [CFG_W-1:0] val);
            case (idx)
                CFG_GRID_WIDTH:  width_reg  = 32'(val);
                CFG_GRID_HEIGHT: height_reg = 32'(val);
                CFG_LAYER_COUNT: layers_reg = 32'(val[2:0]);
                default: return;
            endcase
            restart_pass();
        endfunction

        function bit [ENTRY_W-1:0] peek(int unsigned l, int unsigned c, int unsigned r);
            if (!entry_written[slot(l, c, r)]) unwritten_read = 1'b1;
            return suffix_mem[slot(l, c, r)];
        endfunction

        function void load_cell(bit [7:0] count);
            int unsigned w, h, nl;
            bit [ENTRY_W-1:0] v;
            bit has_right, has_up;
            w  = grid_cols();
            h  = grid_rows();
            nl = grid_layers();
            if (load_lyr >= nl || load_col >= w || load_row >= h) restart_pass();
            has_right = (load_col + 1 < w);
            has_up    = (load_row + 1 < h);
            v = ENTRY_W'(count);
            if (has_right) v += suffix_mem[slot(load_lyr, load_col + 1, load_row)];
            if (has_up) v += suffix_mem[slot(load_lyr, load_col, load_row + 1)];
            if (has_right && has_up)
                v -= suffix_mem[slot(load_lyr, load_col + 1, load_row + 1)];
            suffix_mem[slot(load_lyr, load_col, load_row)]     = v;
            entry_written[slot(load_lyr, load_col, load_row)] = 1'b1;

            // the first cell of a pass starts the running total over
            if (load_lyr == nl - 1 && load_col == w - 1 && load_row == h - 1)
                pass_total = TOTAL_W'(count);
            else
                pass_total = pass_total + TOTAL_W'(count);

            if (load_row > 0) begin
                load_row--;
            end else begin
                load_row = h - 1;
                if (load_col > 0) begin
                    load_col--;
                end else begin
                    load_col = w - 1;
                    load_lyr = (load_lyr > 0) ? load_lyr - 1 : nl - 1;
                end
            end
        endfunction

        // also flags any corner read of an entry never loaded
        function bit [TOTAL_W-1:0] region_sum(t_cell_beat b);
            int xl, yl, xh, yh, fl, lh, w, h, nl;
            bit [TOTAL_W-1:0] sum;
            bit [ENTRY_W-1:0] v;
            bit in_x, in_y;
            unwritten_read = 1'b0;
            w  = int'(grid_cols());
            h  = int'(grid_rows());
            nl = int'(grid_layers());
            xl = (b.x_low < 0) ? 0 : int'(b.x_low);
            yl = (b.y_low < 0) ? 0 : int'(b.y_low);
            xh = (int'(b.x_high) > w - 1) ? w - 1 : int'(b.x_high);
            yh = (int'(b.y_high) > h - 1) ? h - 1 : int'(b.y_high);
            fl = int'(b.first_layer);
            lh = (int'(b.last_layer) > nl - 1) ? nl - 1 : int'(b.last_layer);
            sum = '0;
            if (xl > xh || yl > yh || fl > lh) return sum;
            in_x = (xh + 1 < w);
            in_y = (yh + 1 < h);
            for (int l = fl; l <= lh; l++) begin
                v = peek(l, xl, yl);
                if (in_y) v -= peek(l, xl, yh + 1);
                if (in_x) v -= peek(l, xh + 1, yl);
                if (in_x && in_y) v += peek(l, xh + 1, yh + 1);
                sum += TOTAL_W'(v);
            end
            return sum;
        endfunction

        function void note_beat(t_cell_beat b);
            t_count_pair p;
            if (b.op == OP_LOAD) begin
                load_cell(b.cell_count);
            end else begin
                p.region_count = region_sum(b);
                p.total_count  = pass_total;
                pending_counts = {pending_counts, p};
            end
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_counts(logic [OUT_TDATA_W-1:0] tdata);
            t_count_pair p;
            if (pending_counts.size() == 0) begin
                report_mismatch($sformatf("result beat %h with no query waiting", tdata));
                return;
            end
            p = pending_counts.pop_front();
            if (tdata[TOTAL_W-1:0] !== p.region_count)
                report_mismatch($sformatf("region_count %0d, expected %0d",
                                          tdata[TOTAL_W-1:0], p.region_count));
            if (tdata[2*TOTAL_W-1:TOTAL_W] !== p.total_count)
                report_mismatch($sformatf("total_count %0d, expected %0d",
                                          tdata[2*TOTAL_W-1:TOTAL_W], p.total_count));
        endtask
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata;
    logic [IN_TUSER_W-1:0]   s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_W-1:0]        i_cfg_data;

    t_region_count_tracker sb;
    int send_idle;
    int recv_idle;
    int hold_requests;
    int hold_seen;
    int hold_left;
    int cycle_count;
    int beats_sent;

    layered_suffix_sum_region_counter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold when the sender asks for one
    always @(negedge i_clk) begin
        if (hold_seen != hold_requests) begin
            hold_seen     <= hold_requests;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            sb.check_counts(m_axis_tdata);
    end

    function automatic t_cell_beat make_beat(t_op op, int cnt, int xl, int yl,
                                             int xh, int yh, int fl, int ll);
        t_cell_beat b;
        b.op          = op;
        b.cell_count  = 8'(cnt);
        b.x_low       = shortint'(xl);
        b.y_low       = shortint'(yl);
        b.x_high      = shortint'(xh);
        b.y_high      = shortint'(yh);
        b.first_layer = 2'(fl);
        b.last_layer  = 2'(ll);
        return b;
    endfunction

    function automatic t_cell_beat random_load();
        return make_beat(OP_LOAD, $urandom_range(0, 255), $urandom, $urandom,
                         $urandom, $urandom, $urandom_range(0, 3), $urandom_range(0, 3));
    endfunction

    // retry until the clipped region only touches loaded entries, else go empty
    function automatic t_cell_beat random_query();
        t_cell_beat q;
        int w, h, nl, xl, yl, xh, yh, fl, ll;
        w  = sb.grid_cols();
        h  = sb.grid_rows();
        nl = sb.grid_layers();
        for (int t = 0; t < 16; t++) begin
            case ($urandom_range(0, 3))
                0: begin
                    xl = $urandom; yl = $urandom; xh = $urandom; yh = $urandom;
                    fl = $urandom_range(0, 3);
                    ll = $urandom_range(0, 3);
                end
                1: begin
                    xl = $urandom_range((w > 3) ? w - 3 : 0, w - 1);
                    yl = $urandom_range((h > 3) ? h - 3 : 0, h - 1);
                    xh = $urandom_range(xl, w + 1);
                    yh = $urandom_range(yl, h + 1);
                    fl = ($urandom_range(0, 1) == 0) ? nl - 1 : $urandom_range(0, nl - 1);
                    ll = $urandom_range(fl, 3);
                end
                default: begin
                    xl = int'($urandom_range(0, w + 1)) - 1;
                    yl = int'($urandom_range(0, h + 1)) - 1;
                    xh = xl + int'($urandom_range(0, w));
                    yh = yl + int'($urandom_range(0, h));
                    fl = $urandom_range(0, nl - 1);
                    ll = $urandom_range(fl, 3);
                end
            endcase
            q = make_beat(OP_QUERY, $urandom_range(0, 255), xl, yl, xh, yh, fl, ll);
            void'(sb.region_sum(q));
            if (!sb.unwritten_read) return q;
        end
        return make_beat(OP_QUERY, $urandom_range(0, 255), 1, 0, 0, 0, 0, 0);
    endfunction

    // call at a falling edge; returns at the falling edge after acceptance
    task automatic send_beat(t_cell_beat b);
        while ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= b.op;
        s_axis_tdata  <= {4'b0, b.last_layer, b.first_layer, b.y_high, b.x_high,
                          b.y_low, b.x_low, b.cell_count};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.note_beat(b);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (sb.pending_counts.size() != 0);
    endtask

    // hold the input idle through any load still in flight, then write all three
    task automatic program_grid(int w, int h, int l);
        t_cfg_index idx [3];
        int         val [3];
        idx = '{CFG_GRID_WIDTH, CFG_GRID_HEIGHT, CFG_LAYER_COUNT};
        val = '{w, h, l};
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        for (int i = 0; i < 3; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data  <= CFG_W'(val[i]);
            @(posedge i_clk);
            sb.write_config(idx[i], CFG_W'(val[i]));
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int k, w, h, l, n_beats, pass_cells;
        t_cell_beat dir_beats [$];

        sb            = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = CFG_GRID_WIDTH;
        i_cfg_data    = '0;
        send_idle     = 21;
        recv_idle     = 64;
        hold_requests = 0;
        hold_seen     = 0;
        hold_left     = 0;
        cycle_count   = 0;
        beats_sent    = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: one full pass of a 2x2x2 grid, clipping corners, empty regions, wrap
        program_grid(2, 2, 2);
        dir_beats = {dir_beats, make_beat(OP_LOAD, 255, 0, 0, 0, 0, 0, 0)};
        dir_beats = {dir_beats, make_beat(OP_LOAD, 0, 0, 0, 0, 0, 0, 0)};
        dir_beats = {dir_beats, make_beat(OP_LOAD, 17, 0, 0, 0, 0, 0, 0)};
        dir_beats = {dir_beats, make_beat(OP_LOAD, 255, 0, 0, 0, 0, 0, 0)};
        dir_beats = {dir_beats, make_beat(OP_LOAD, 1, 0, 0, 0, 0, 0, 0)};
        dir_beats = {dir_beats, make_beat(OP_LOAD, 2, 0, 0, 0, 0, 0, 0)};
        dir_beats = {dir_beats, make_beat(OP_LOAD, 3, 0, 0, 0, 0, 0, 0)};
        dir_beats = {dir_beats, make_beat(OP_LOAD, 4, 0, 0, 0, 0, 0, 0)};
        dir_beats = {dir_beats, make_beat(OP_QUERY, 0, -32768, -32768, 32767, 32767, 0, 3)};
        dir_beats = {dir_beats, make_beat(OP_QUERY, 255, 0, 0, 1, 1, 3, 3)};
        dir_beats = {dir_beats, make_beat(OP_QUERY, 0, 0, 0, 1, 1, 1, 0)};
        dir_beats = {dir_beats, make_beat(OP_QUERY, 0, 1, 0, 0, 1, 0, 1)};
        dir_beats = {dir_beats, make_beat(OP_QUERY, 0, 1, 0, 1, 0, 1, 1)};
        dir_beats = {dir_beats, make_beat(OP_QUERY, 0, 0, 1, 0, 32767, 0, 0)};
        dir_beats = {dir_beats, make_beat(OP_QUERY, 0, 32767, 0, -32768, 1, 0, 1)};
        dir_beats = {dir_beats, make_beat(OP_QUERY, 0, 0, -1, 1, -1, 0, 1)};
        dir_beats = {dir_beats, make_beat(OP_LOAD, 200, 0, 0, 0, 0, 0, 0)};
        dir_beats = {dir_beats, make_beat(OP_QUERY, 0, -32768, -32768, 32767, 32767, 0, 3)};
        foreach (dir_beats[i]) send_beat(dir_beats[i]);

        // random phases: fixed extremes first, then small random grids
        k = 0;
        while (beats_sent < RANDOM_BEATS) begin
            case (k)
                0: begin w = 511; h = 300; l = 7; end
                1: begin w = 0;   h = 0;   l = 0; end
                2: begin w = 256; h = 1;   l = 4; end
                3: begin w = 1;   h = 256; l = 3; end
                default: begin
                    w = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 16 : 6);
                    h = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 16 : 6);
                    l = $urandom_range(0, 7);
                end
            endcase
            program_grid(w, h, l);
            if (beats_sent < RANDOM_BEATS / 3) begin
                send_idle = 21; recv_idle = 64;
            end else if (beats_sent < 2 * RANDOM_BEATS / 3) begin
                send_idle = 64; recv_idle = 21;
            end else begin
                send_idle = 0;  recv_idle = 0;
            end
            pass_cells = sb.grid_cols() * sb.grid_rows() * sb.grid_layers();
            n_beats = (k < 4) ? 300 : ((3 * pass_cells + 20 > 300) ? 300 : 3 * pass_cells + 20);
            if (k % 2 == 0) hold_requests <= hold_requests + 1;
            for (int i = 0; i < n_beats; i++) begin
                if (i == n_beats / 2) wait_drained();
                if ($urandom_range(0, 99) < 35) send_beat(random_query());
                else send_beat(random_load());
                beats_sent++;
            end
            k++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### layered_suffix_sum_region_counter.f
hdl/lssrc_pkg.sv
hdl/lssrc_ctrl.sv
hdl/lssrc_dpath.sv
hdl/layered_suffix_sum_region_counter.sv
hdl/lssrc_checker.sv
test/layered_suffix_sum_region_counter_test.sv
